// ----- rtl/bhd_pkg.sv -----
package bhd_pkg;

    // group geometry
    localparam int NUM_CHARS = 8;
    localparam int NUM_BYTES = 5;
    localparam int DIG_W     = 5;
    localparam int CNT_W     = 3;

    // character codes of the alphabet
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_V = 8'h56;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_V = 8'h76;
    localparam logic [7:0] CH_PAD     = 8'h3d;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    // byte counts of a final group
    localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
    localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;
    localparam logic [CNT_W-1:0] CNT_FULL  = 3'd5;

    // one classified character
    typedef struct packed {
        logic [DIG_W-1:0] val;
        logic             is_dig;
        logic             is_pad;
    } digit_t;

    typedef digit_t [NUM_CHARS-1:0] digit_vec_t;

    // one decoded transaction
    typedef struct packed {
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [7:0]       byte2;
        logic [7:0]       byte3;
        logic [7:0]       byte4;
        logic [CNT_W-1:0] byte_count;
        logic             bad_group;
        logic             last_of_message;
    } result_t;

endpackage

// ----- rtl/bhd_if.sv -----
interface bhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
    logic [7:0] char4;
    logic [7:0] char5;
    logic [7:0] char6;
    logic [7:0] char7;
    logic       final_group;

    modport source (
        output valid, char0, char1, char2, char3, char4, char5, char6, char7, final_group,
        input  ready
    );
    modport sink (
        input  valid, char0, char1, char2, char3, char4, char5, char6, char7, final_group,
        output ready
    );
endinterface

interface bhd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [2:0] byte_count;
    logic       bad_group;
    logic       last_of_message;

    modport source (
        output valid, byte0, byte1, byte2, byte3, byte4, byte_count, bad_group,
               last_of_message,
        input  ready
    );
    modport sink (
        input  valid, byte0, byte1, byte2, byte3, byte4, byte_count, bad_group,
               last_of_message,
        output ready
    );
endinterface

// ----- rtl/bhd_lane.sv -----
module bhd_lane (
    input  logic [7:0]     ch,
    output bhd_pkg::digit_t dig
);

    logic [7:0] ofs;

    // map one character to its 5-bit digit, padding or invalid
    always_comb
    begin
        dig = '0;
        ofs = '0;
        case (ch) inside
            [bhd_pkg::CH_ZERO : bhd_pkg::CH_NINE]:
            begin
                ofs        = ch - bhd_pkg::CH_ZERO;
                dig.val    = ofs[bhd_pkg::DIG_W-1:0];
                dig.is_dig = 1'b1;
            end
            [bhd_pkg::CH_UPPER_A : bhd_pkg::CH_UPPER_V]:
            begin
                ofs        = ch - bhd_pkg::CH_UPPER_A + bhd_pkg::LETTER_OFS;
                dig.val    = ofs[bhd_pkg::DIG_W-1:0];
                dig.is_dig = 1'b1;
            end
            [bhd_pkg::CH_LOWER_A : bhd_pkg::CH_LOWER_V]:
            begin
                ofs        = ch - bhd_pkg::CH_LOWER_A + bhd_pkg::LETTER_OFS;
                dig.val    = ofs[bhd_pkg::DIG_W-1:0];
                dig.is_dig = 1'b1;
            end
            bhd_pkg::CH_PAD:
            begin
                dig.is_pad = 1'b1;
            end
            default:
            begin
                dig = '0;
            end
        endcase
    end

endmodule

// ----- rtl/bhd_merge.sv -----
module bhd_merge (
    input  bhd_pkg::digit_vec_t digs,
    input  logic                final_group,
    output bhd_pkg::result_t    res
);

    logic [bhd_pkg::NUM_BYTES-1:0][7:0] by;
    logic [bhd_pkg::NUM_BYTES-1:0][7:0] by_masked;
    logic [bhd_pkg::NUM_CHARS-1:0]      dig_ok;
    logic [bhd_pkg::NUM_CHARS-1:0]      pad;
    logic [bhd_pkg::CNT_W-1:0]          cnt;
    logic                               bad;

    // pack the forty digit bits into five bytes
    always_comb
    begin
        by[0] = {digs[0].val, digs[1].val[4:2]};
        by[1] = {digs[1].val[1:0], digs[2].val, digs[3].val[4]};
        by[2] = {digs[3].val[3:0], digs[4].val[4:1]};
        by[3] = {digs[4].val[0], digs[5].val, digs[6].val[4:3]};
        by[4] = {digs[6].val[2:0], digs[7].val};
    end

    always_comb
    begin
        for (int i = 0; i < bhd_pkg::NUM_CHARS; i++)
        begin
            dig_ok[i] = digs[i].is_dig;
            pad[i]    = digs[i].is_pad;
        end
    end

    // byte count and error: full group or final group with early stop
    always_comb
    begin
        cnt = bhd_pkg::CNT_NONE;
        bad = 1'b0;
        if (!final_group)
        begin
            bad = !(&dig_ok);
            cnt = bad ? bhd_pkg::CNT_NONE : bhd_pkg::CNT_FULL;
        end
        else if (!dig_ok[0] || !dig_ok[1])
        begin
            bad = 1'b1;
        end
        else
        begin
            cnt = bhd_pkg::CNT_ONE;
            if (!pad[2] && !pad[3])
            begin
                if (!dig_ok[2] || !dig_ok[3])
                begin
                    bad = 1'b1;
                end
                else
                begin
                    cnt = bhd_pkg::CNT_TWO;
                    if (!pad[4])
                    begin
                        if (!dig_ok[4])
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            cnt = bhd_pkg::CNT_THREE;
                            if (!pad[5] && !pad[6])
                            begin
                                if (!dig_ok[5] || !dig_ok[6])
                                begin
                                    bad = 1'b1;
                                end
                                else
                                begin
                                    cnt = bhd_pkg::CNT_FOUR;
                                    if (!pad[7])
                                    begin
                                        if (!dig_ok[7])
                                        begin
                                            bad = 1'b1;
                                        end
                                        else
                                        begin
                                            cnt = bhd_pkg::CNT_FULL;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
            end
            if (bad)
            begin
                cnt = bhd_pkg::CNT_NONE;
            end
        end
    end

    // zero the bytes at and above the count
    always_comb
    begin
        for (int i = 0; i < bhd_pkg::NUM_BYTES; i++)
        begin
            by_masked[i] = (bhd_pkg::CNT_W'(i) < cnt) ? by[i] : 8'h00;
        end
    end

    assign res.byte0           = by_masked[0];
    assign res.byte1           = by_masked[1];
    assign res.byte2           = by_masked[2];
    assign res.byte3           = by_masked[3];
    assign res.byte4           = by_masked[4];
    assign res.byte_count      = cnt;
    assign res.bad_group       = bad;
    assign res.last_of_message = final_group;

endmodule

// ----- rtl/base32hex_group_decoder_top.sv -----
// base32hex group decoder: eight characters in, up to five bytes out per transaction
// an input transaction passes the lane register, then the output register, before output valid
// throughput: one group per cycle unless the output is held; eight classify lanes and one merge stage, no iteration
// the pipeline stalls stage by stage, so input stays ready while a result waits
// and the lane register is empty
// reset: rst_n asynchronous active low clears both valid flags; no clearing pass
module base32hex_group_decoder_top (
    input  logic             clk,
    input  logic             rst_n,
    bhd_in_if.sink           in_ch,
    bhd_out_if.source        out_ch
);

    logic [bhd_pkg::NUM_CHARS-1:0][7:0] chars;
    bhd_pkg::digit_vec_t                lane_dig;
    bhd_pkg::digit_vec_t                dig_reg;
    logic                               final_reg;
    logic                               s1_valid_reg;
    logic                               s1_valid_next;
    bhd_pkg::result_t                   merge_res;
    bhd_pkg::result_t                   res_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_free;
    logic                               in_take;

    assign chars = {in_ch.char7, in_ch.char6, in_ch.char5, in_ch.char4,
                    in_ch.char3, in_ch.char2, in_ch.char1, in_ch.char0};

    // classify lanes, one per character
    for (genvar g = 0; g < bhd_pkg::NUM_CHARS; g++)
    begin : g_lane
        bhd_lane u_lane (
            .ch  (chars[g]),
            .dig (lane_dig[g])
        );
    end

    // stall control
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next  = in_ch.ready ? in_ch.valid : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // lane register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dig_reg   <= lane_dig;
            final_reg <= in_ch.final_group;
        end
    end

    // merge stage
    bhd_merge u_merge (
        .digs        (dig_reg),
        .final_group (final_reg),
        .res         (merge_res)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            res_reg <= merge_res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.byte0           = res_reg.byte0;
    assign out_ch.byte1           = res_reg.byte1;
    assign out_ch.byte2           = res_reg.byte2;
    assign out_ch.byte3           = res_reg.byte3;
    assign out_ch.byte4           = res_reg.byte4;
    assign out_ch.byte_count      = res_reg.byte_count;
    assign out_ch.bad_group       = res_reg.bad_group;
    assign out_ch.last_of_message = res_reg.last_of_message;

    // input only stalls when both stages hold a transaction and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && out_ch.valid && !out_ch.ready))
        else $error("input stalled while the pipeline has room");

    // an accepted transaction lands in the lane register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted transaction lost at the lane register");

    // an error never carries bytes
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.bad_group) |-> (out_ch.byte_count == bhd_pkg::CNT_NONE))
        else $error("bad group with nonzero byte count");

    // a good non-final group always gives five bytes
    a_full_group: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.bad_group && !out_ch.last_of_message)
            |-> (out_ch.byte_count == bhd_pkg::CNT_FULL))
        else $error("good non-final group without five bytes");

endmodule
